@@ design/egcd_pkg.sv @@
`default_nettype none

package egcd_pkg;

   // Coefficients are kept modulo 2^32, which is all the result carries.
   localparam int COEFF_WIDTH = 32;

   typedef struct packed {
      logic load;       // capture operands and seed the coefficient pairs
      logic div_start;  // clear the divider for a new quotient
      logic div_step;   // one restoring-division bit
      logic update;     // rotate remainder and coefficient pairs
      logic capture;    // move the finished result to the output register
   } egcd_cmd_type;

   typedef struct packed {
      logic r1_zero;    // current divisor is zero, the loop is done
   } egcd_status_type;

endpackage

`default_nettype wire

@@ design/egcd_datapath.sv @@
`default_nettype none

module egcd_datapath
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic                     clock,
   input  wire egcd_cmd_type             cmd,
   input  wire logic [OPERAND_WIDTH-1:0] first_value,
   input  wire logic [OPERAND_WIDTH-1:0] second_value,
   output egcd_status_type               status,
   output logic [OPERAND_WIDTH-1:0]      divisor,
   output logic signed [COEFF_WIDTH-1:0] coeff_first,
   output logic signed [COEFF_WIDTH-1:0] coeff_second
);

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]           r0_ff, r1_ff, rem_ff, num_ff;
   logic [COEFF_WIDTH-1:0] s0_ff, s1_ff, t0_ff, t1_ff, acc_s_ff, acc_t_ff;
   logic [W-1:0]           out_div_ff;
   logic [COEFF_WIDTH-1:0] out_s_ff, out_t_ff;

   logic [W:0]             trial;
   logic [W:0]             diff;
   logic                   fits;
   logic [W-1:0]           rem_in;
   logic [COEFF_WIDTH-1:0] acc_s_in, acc_t_in;

   // Restoring division, one quotient bit per cycle, MSB first. The products
   // q*s1 and q*t1 are built alongside by shift-and-add on the quotient bits.
   always_comb begin
      trial    = {rem_ff, num_ff[W-1]};
      diff     = trial - {1'b0, r1_ff};
      fits     = trial >= {1'b0, r1_ff};
      rem_in   = fits ? diff[W-1:0] : trial[W-1:0];
      acc_s_in = {acc_s_ff[COEFF_WIDTH-2:0], 1'b0} + (fits ? s1_ff : '0);
      acc_t_in = {acc_t_ff[COEFF_WIDTH-2:0], 1'b0} + (fits ? t1_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r0_ff <= first_value;
         r1_ff <= second_value;
         s0_ff <= COEFF_WIDTH'(1);
         s1_ff <= '0;
         t0_ff <= '0;
         t1_ff <= COEFF_WIDTH'(1);
      end
      if (cmd.div_start) begin
         rem_ff   <= '0;
         num_ff   <= r0_ff;
         acc_s_ff <= '0;
         acc_t_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff   <= rem_in;
         num_ff   <= {num_ff[W-2:0], 1'b0};
         acc_s_ff <= acc_s_in;
         acc_t_ff <= acc_t_in;
      end
      if (cmd.update) begin
         r0_ff <= r1_ff;
         r1_ff <= rem_ff;
         s0_ff <= s1_ff;
         s1_ff <= s0_ff - acc_s_ff;
         t0_ff <= t1_ff;
         t1_ff <= t0_ff - acc_t_ff;
      end
      if (cmd.capture) begin
         out_div_ff <= r0_ff;
         out_s_ff   <= s0_ff;
         out_t_ff   <= t0_ff;
      end
   end

   assign status.r1_zero = (r1_ff == '0);
   assign divisor        = out_div_ff;
   assign coeff_first    = out_s_ff;
   assign coeff_second   = out_t_ff;

endmodule

`default_nettype wire

@@ design/egcd_ctrl.sv @@
`default_nettype none

module egcd_ctrl
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire egcd_status_type status,
   output egcd_cmd_type         cmd
);

   localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(OPERAND_WIDTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_UPDATE,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             slot_free;

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.r1_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_CHECK;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.capture  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/extended_gcd_unit.sv @@
// Extended Euclidean unit: for operands a and b it returns g = gcd(a, b)
// and coefficients x, y (two's complement, modulo 2^32) with a*x + b*y = g.
// Request channel req_*: one item holds a and b. Response channel rsp_*:
// one item per request holds g, x and y. Both use a valid/ready handshake.
// One item is worked on at a time; req_tready is high only while idle.
// Each Euclid iteration has a check state, then one restoring-division bit
// per cycle on the shared divider for OPERAND_WIDTH bits, then an update
// state. Once the loop is done the result is captured, and the next item
// can be accepted when the unit is back in idle; at the default width the
// worst case is about 46 iterations. b = 0 answers (a, 1, 0) with no
// division.
// The result sits in an output register, so a new item is accepted as soon
// as the previous one is captured, even if the receiver still stalls it.
// A finished item waits only if the output register is still occupied.
// Reset (synchronous, active high) returns to idle and drops any pending
// response; no other state is kept between items.
`default_nettype none

module extended_gcd_unit
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // first_value, second_value (lowest bits first), zero padded
   input  wire logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // divisor, coeff_first, coeff_second (lowest bits first), zero padded
   output logic [((OPERAND_WIDTH+2*COEFF_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int W     = OPERAND_WIDTH;
   localparam int RSP_W = ((W + 2*COEFF_WIDTH + 7) / 8) * 8;

   egcd_cmd_type                 cmd;
   egcd_status_type              status;
   logic [W-1:0]                 divisor;
   logic signed [COEFF_WIDTH-1:0] coeff_first, coeff_second;

   egcd_ctrl #(
      .OPERAND_WIDTH(W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   egcd_datapath #(
      .OPERAND_WIDTH(W)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .first_value  (req_tdata[W-1:0]),
      .second_value (req_tdata[2*W-1:W]),
      .status       (status),
      .divisor      (divisor),
      .coeff_first  (coeff_first),
      .coeff_second (coeff_second)
   );

   assign rsp_tdata = RSP_W'({coeff_second, coeff_first, divisor});

   // At most one datapath command is issued in any cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.update, cmd.capture}))
      else $error("more than one datapath command at once");

   // A result is captured only once the remainder has reached zero.
   a_capture_done: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> status.r1_zero)
      else $error("result captured before the iteration finished");

   // An update always directly follows the last division step.
   a_update_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.div_step))
      else $error("update issued without a finished division");

   // Capturing never overwrites a response that is still being held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_tvalid || rsp_tready))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

@@ verif/extended_gcd_unit_tb.sv @@
`timescale 1ns / 100ps

module extended_gcd_unit_tb;
   import egcd_pkg::*;

   localparam int OPERAND_WIDTH = 31;
   localparam int REQ_WIDTH = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
   localparam int RSP_WIDTH = ((OPERAND_WIDTH + 2 * COEFF_WIDTH + 7) / 8) * 8;
   localparam logic [OPERAND_WIDTH-1:0] OPERAND_MAX = '1;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 1600;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;

   typedef struct {
      logic [OPERAND_WIDTH-1:0] divisor;
      logic [COEFF_WIDTH-1:0]   coeff_first;
      logic [COEFF_WIDTH-1:0]   coeff_second;
   } bezout_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // first_value, second_value (lowest bits first), zero padded
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // divisor, coeff_first, coeff_second (lowest bits first), zero padded
   logic [RSP_WIDTH-1:0] rsp_tdata;

   bezout_result_type pending_bezout[$];
   int             error_count = 0;
   int             req_idle_pct = 0;
   int             rsp_stall_pct = 0;
   logic           rsp_hold_active = 1'b0;
   event           start_rsp_hold;

   extended_gcd_unit #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // Euclid iteration with all arithmetic modulo 2^64; the result keeps the low bits.
   function automatic bezout_result_type solve_bezout(input operand_type a,
                                                      input operand_type b);
      bit [63:0]         r0, r1, s0, s1, t0, t1, q, nr, ns, nt;
      bezout_result_type res;
      r0 = 64'(a);
      r1 = 64'(b);
      s0 = 64'd1;
      s1 = 64'd0;
      t0 = 64'd0;
      t1 = 64'd1;
      while (r1 != 64'd0) begin
         q = r0 / r1;
         nr = r0 - q * r1;
         ns = s0 - q * s1;
         nt = t0 - q * t1;
         r0 = r1;
         r1 = nr;
         s0 = s1;
         s1 = ns;
         t0 = t1;
         t1 = nt;
      end
      res.divisor = r0[OPERAND_WIDTH-1:0];
      res.coeff_first = s0[COEFF_WIDTH-1:0];
      res.coeff_second = t0[COEFF_WIDTH-1:0];
      return res;
   endfunction

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_operands(input operand_type a, input operand_type b);
      logic [REQ_WIDTH-1:0] word;
      word = '0;
      word[OPERAND_WIDTH-1:0] = a;
      word[2*OPERAND_WIDTH-1:OPERAND_WIDTH] = b;
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      pending_bezout.push_back(solve_bezout(a, b));
   endtask

   task automatic stop_sending;
      req_tvalid <= 1'b0;
   endtask

   task automatic pick_operands(output operand_type a, output operand_type b);
      longint unsigned fib_lo, fib_hi, nxt, scale, factor;
      int              kind;
      operand_type     swap;
      kind = $urandom_range(99);
      if (kind < 35) begin
         a = operand_type'($urandom);
         b = operand_type'($urandom);
      end else if (kind < 55) begin
         a = operand_type'($urandom_range(255));
         b = operand_type'($urandom_range(255));
      end else if (kind < 72) begin
         // Operands sharing a common factor.
         factor = $urandom_range(1, 65536);
         a = operand_type'(factor * $urandom_range(0, 32'(OPERAND_MAX / factor)));
         b = operand_type'(factor * $urandom_range(0, 32'(OPERAND_MAX / factor)));
      end else if (kind < 87) begin
         // Scaled consecutive Fibonacci numbers give the longest chains.
         fib_lo = 1;
         fib_hi = 1;
         repeat ($urandom_range(44)) begin
            nxt = fib_lo + fib_hi;
            fib_lo = fib_hi;
            fib_hi = nxt;
         end
         scale = $urandom_range(1, 32'(OPERAND_MAX / fib_hi));
         a = operand_type'(fib_hi * scale);
         b = operand_type'(fib_lo * scale);
      end else if (kind < 92) begin
         a = operand_type'($urandom);
         b = a;
      end else if (kind < 96) begin
         a = operand_type'($urandom);
         b = '0;
      end else begin
         // One operand an exact multiple of the other.
         b = operand_type'($urandom_range(1, 100000));
         a = operand_type'(b * $urandom_range(0, 32'(OPERAND_MAX / b)));
      end
      if ($urandom_range(1) == 1) begin
         swap = a;
         a = b;
         b = swap;
      end
   endtask

   task automatic test_zero_operands;
      send_operands('0, '0);
      send_operands(31'd5, '0);
      send_operands(OPERAND_MAX, '0);
      send_operands(31'd1, '0);
      send_operands('0, 31'd7);
      send_operands('0, OPERAND_MAX);
      send_operands('0, 31'd1);
   endtask

   task automatic test_operand_extremes;
      send_operands(OPERAND_MAX, OPERAND_MAX);
      send_operands(OPERAND_MAX, OPERAND_MAX - 31'd1);
      send_operands(OPERAND_MAX, 31'd1);
      send_operands(31'd1, OPERAND_MAX);
      send_operands(31'd1, 31'd1);
      send_operands(31'h2AAAAAAA, 31'h55555555);
      send_operands(31'h55555555, 31'h2AAAAAAA);
      send_operands(OPERAND_MAX, 31'd2147483629);
      send_operands(31'h40000000, 31'h30000000);
      send_operands(31'd1000000, 31'd1000);
      send_operands(31'd3, 31'd7);
      send_operands(31'd12, 31'd12);
   endtask

   task automatic test_worst_case_chains;
      send_operands(31'd1836311903, 31'd1134903170);
      send_operands(31'd1134903170, 31'd1836311903);
   endtask

   // The receiver holds off while items keep coming, so the block fills and stalls.
   task automatic test_output_backpressure;
      operand_type a, b;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      -> start_rsp_hold;
      repeat (8) begin
         a = operand_type'($urandom_range(255));
         b = operand_type'($urandom_range(3));
         send_operands(a, b);
      end
      while (rsp_hold_active) @(posedge clock);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      operand_type a, b;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick_operands(a, b);
         send_operands(a, b);
      end
   endtask

   initial forever begin
      @(start_rsp_hold);
      rsp_hold_active <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold_active <= 1'b0;
   end

   // Result checker and receiver ready generation.
   always @(posedge clock) begin
      bezout_result_type want;
      logic [OPERAND_WIDTH-1:0] got_divisor;
      logic [COEFF_WIDTH-1:0]   got_first, got_second;
      got_divisor = rsp_tdata[OPERAND_WIDTH-1:0];
      got_first = rsp_tdata[OPERAND_WIDTH+COEFF_WIDTH-1:OPERAND_WIDTH];
      got_second = rsp_tdata[OPERAND_WIDTH+2*COEFF_WIDTH-1:OPERAND_WIDTH+COEFF_WIDTH];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bezout.size() == 0) begin
            $error("unexpected result item: divisor %0d", got_divisor);
            error_count++;
         end else begin
            want = pending_bezout.pop_front();
            if (got_divisor !== want.divisor) begin
               $error("divisor: expected %0d, actual %0d", want.divisor, got_divisor);
               error_count++;
            end
            if (got_first !== want.coeff_first) begin
               $error("coeff_first: expected %0d, actual %0d",
                      $signed(want.coeff_first), $signed(got_first));
               error_count++;
            end
            if (got_second !== want.coeff_second) begin
               $error("coeff_second: expected %0d, actual %0d",
                      $signed(want.coeff_second), $signed(got_second));
               error_count++;
            end
         end
      end
      if (rsp_hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_operands();
      test_operand_extremes();
      test_worst_case_chains();
      test_output_backpressure();
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 51, 0);
      test_random_traffic(100, 0, 51);
      test_random_traffic(100, 12, 12);
      stop_sending();
      while (pending_bezout.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
